[rtl/tccw_pkg.sv]
`default_nettype none
package tccw_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } state_type;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   localparam logic [7:0] COLOR_RESET = 8'h07;

   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic                load;
      logic [CURSOR_W-1:0] cursor;
      logic [CELL_W-1:0]   data;
      logic                scrolled;
   } result_type;

endpackage
`default_nettype wire

[rtl/tccw_ram.sv]
`default_nettype none
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/tccw_seq.sv]
`default_nettype none
module tccw_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELLS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [7:0]                   req_char,
   input  wire logic [10:0]                  req_index,
   input  wire logic [7:0]                   text_color,
   input  wire logic                         out_free,
   output tccw_pkg::result_type              result,
   output logic                              ram_wr_en,
   output logic [ADDR_W-1:0]                 ram_wr_addr,
   output logic [tccw_pkg::CELL_W-1:0]       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [ADDR_W-1:0]                 ram_rd_addr,
   input  wire logic [tccw_pkg::CELL_W-1:0]  ram_rd_data
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] SRC_END  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);

   tccw_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic              scrolled_ff, scrolled_in;

   logic [ADDR_W-1:0] cur;
   logic [ADDR_W-1:0] cur_next;
   logic [COL_W:0]    tab_col;
   logic [15:0]       index_ext;
   logic [15:0]       cursor_ext;
   logic [tccw_pkg::CELL_W-1:0] blank;

   assign cur       = base_ff + ADDR_W'(col_ff);
   assign cur_next  = base_in + ADDR_W'(col_in);
   assign tab_col   = ({1'b0, col_ff} | (COL_W+1)'(7)) + (COL_W+1)'(1);
   assign index_ext = 16'(req_index);
   assign cursor_ext = 16'(cur_next);
   assign blank     = {text_color, tccw_pkg::CHAR_BLANK};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tccw_pkg::ST_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         pend_ff     <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         base_ff     <= base_in;
         pend_ff     <= pend_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dst_ff <= dst_in;
   end

   always_comb begin
      logic go_scroll;
      logic walk;
      logic issue;
      go_scroll       = 1'b0;
      walk            = 1'b0;
      issue           = 1'b0;
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      base_in         = base_ff;
      cnt_in          = cnt_ff;
      dst_in          = dst_ff;
      pend_in         = 1'b0;
      scrolled_in     = scrolled_ff;
      req_ready       = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = '0;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = '0;
      result.load     = 1'b0;
      result.data     = '0;
      result.scrolled = 1'b0;

      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               case (req_kind)
                  tccw_pkg::KIND_PUT: begin
                     case (req_char)
                        tccw_pkg::CHAR_NEWLINE: begin
                           if (row_ff == LAST_ROW) begin
                              go_scroll = 1'b1;
                           end else begin
                              row_in  = row_ff + ROW_W'(1);
                              base_in = base_ff + COLS_A;
                              col_in  = '0;
                           end
                        end
                        tccw_pkg::CHAR_RETURN: begin
                           col_in = '0;
                        end
                        tccw_pkg::CHAR_BACKSPACE: begin
                           if (cur != '0) begin
                              if (col_ff != '0) begin
                                 col_in = col_ff - COL_W'(1);
                              end else begin
                                 row_in  = row_ff - ROW_W'(1);
                                 base_in = base_ff - COLS_A;
                                 col_in  = LAST_COL;
                              end
                              ram_wr_en   = 1'b1;
                              ram_wr_addr = cur - ADDR_W'(1);
                              ram_wr_data = blank;
                           end
                        end
                        tccw_pkg::CHAR_TAB: begin
                           if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                              col_in = LAST_COL;
                           end else begin
                              col_in = tab_col[COL_W-1:0];
                           end
                        end
                        default: begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = cur;
                           ram_wr_data = {text_color, req_char};
                           if (col_ff == LAST_COL) begin
                              if (row_ff == LAST_ROW) begin
                                 go_scroll = 1'b1;
                              end else begin
                                 row_in  = row_ff + ROW_W'(1);
                                 base_in = base_ff + COLS_A;
                                 col_in  = '0;
                              end
                           end else begin
                              col_in = col_ff + COL_W'(1);
                           end
                        end
                     endcase
                     if (go_scroll) begin
                        row_in      = LAST_ROW;
                        base_in     = SRC_END;
                        col_in      = '0;
                        cnt_in      = '0;
                        scrolled_in = 1'b1;
                        walk        = 1'b1;
                        state_in    = tccw_pkg::ST_COPY;
                     end
                  end
                  tccw_pkg::KIND_CLEAR: begin
                     row_in      = '0;
                     base_in     = '0;
                     col_in      = '0;
                     cnt_in      = '0;
                     scrolled_in = 1'b0;
                     walk        = 1'b1;
                     state_in    = tccw_pkg::ST_BLANK;
                  end
                  tccw_pkg::KIND_READ: begin
                     if (index_ext < 16'(CELLS)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = index_ext[ADDR_W-1:0];
                        walk        = 1'b1;
                        state_in    = tccw_pkg::ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               result.load = !walk;
            end
         end
         tccw_pkg::ST_READ: begin
            if (out_free) begin
               result.load = 1'b1;
               result.data = ram_rd_data;
               state_in    = tccw_pkg::ST_IDLE;
            end
         end
         tccw_pkg::ST_COPY: begin
            // reads run one cell ahead of the writes one row lower
            issue = (cnt_ff != SRC_END);
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff + COLS_A;
               cnt_in      = cnt_ff + ADDR_W'(1);
               dst_in      = cnt_ff;
            end else begin
               state_in = tccw_pkg::ST_BLANK;
            end
            pend_in = issue;
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff;
               ram_wr_data = ram_rd_data;
            end
         end
         tccw_pkg::ST_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = blank;
            cnt_in      = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_A) begin
               state_in = tccw_pkg::ST_DONE;
            end
         end
         tccw_pkg::ST_DONE: begin
            if (out_free) begin
               result.load     = 1'b1;
               result.scrolled = scrolled_ff;
               state_in        = tccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase

      if (state_ff == tccw_pkg::ST_IDLE) begin
         result.scrolled = 1'b0;
      end
      result.cursor = cursor_ext[tccw_pkg::CURSOR_W-1:0];
   end

endmodule
`default_nettype wire

[rtl/text_console_cell_writer.sv]
// Results: a put, an out-of-range read and an unused kind are answered from idle;
// a read waits on the frame store; clears and scrolling puts walk the store first.
// Throughput: one put without scroll per cycle while the response is not stalled; a
// read holds off the next item while the store answers; walks hold off new items.
// Reset: synchronous, clears cursor, color (to 7) and handshake state; the
// frame store holds garbage until a clear or a put writes it.
`default_nettype none
module text_console_cell_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // char_code[7:0], cell_index[18:8], zero fill
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // cursor_position[10:0], cell_data[26:11],
                                        // scrolled[27], zero fill
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   logic [7:0]  color_ff;
   logic        rsp_valid_ff;
   logic [10:0] rsp_cursor_ff;
   logic [15:0] rsp_data_ff;
   logic        rsp_scrolled_ff;
   logic        out_free;

   tccw_pkg::result_type result;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [15:0]       ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [15:0]       ram_rd_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= tccw_pkg::COLOR_RESET;
      end else if (csr_valid) begin
         color_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_cursor_ff   <= result.cursor;
         rsp_data_ff     <= result.data;
         rsp_scrolled_ff <= result.scrolled;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_scrolled_ff, rsp_data_ff, rsp_cursor_ff};

   tccw_seq #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_index  (req_tdata[18:8]),
      .text_color (color_ff),
      .out_free   (out_free),
      .result     (result),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   tccw_ram #(
      .WIDTH(16),
      .DEPTH(CELLS)
   ) u_frame (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule
`default_nettype wire

[rtl/tccw_checker.sv]
`default_nettype none
module tccw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam logic [10:0] SCROLL_POS = 11'(CELLS - COLUMNS);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // a scroll leaves the cursor at the start of the last row
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |-> rsp_tdata[10:0] == SCROLL_POS)
      else $error("scroll with wrong cursor");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |-> rsp_tdata[26:11] == 16'd0)
      else $error("scroll result carries cell data");

endmodule

bind text_console_cell_writer tccw_checker #(
   .COLUMNS(COLUMNS),
   .ROWS   (ROWS)
) u_tccw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
